// ===== rtl/core/median_of_two_sorted_arrays_unit_defines.svh =====
// Assertion macros shared by the median unit's RTL files.
// Depends on nothing; the using module provides clk_i and rst_ni.
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_UNIT_DEFINES_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define MOSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define MOSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/mosa_pkg.sv =====
// Types, codes and sizes shared by the median unit's controller, datapath and top level.
// Depends on nothing.
package mosa_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TOT_W  = CNT_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH_FIRST  = 2'd0,
    KIND_PUSH_SECOND = 2'd1,
    KIND_COMPUTE     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [32:0] median_doubled;
    logic [1:0]         status;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic push_first;
    logic push_second;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dropped;
    logic empty;
    logic last_step;
  } stat_t;

endpackage

// ===== rtl/core/mosa_ctrl.sv =====
// Controller of the median unit: decodes transactions and sequences the merge walk.
// Depends on mosa_pkg and the shared assertion macros.
`include "median_of_two_sorted_arrays_unit_defines.svh"

module mosa_ctrl import mosa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] kind_i,
  input  stat_t      stat_i,
  output logic       busy,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_i)
            KIND_PUSH_FIRST:  cmd_o.push_first  = 1'b1;
            KIND_PUSH_SECOND: cmd_o.push_second = 1'b1;
            KIND_COMPUTE: begin
              // report at once when there is nothing to walk
              if (stat_i.dropped || stat_i.empty) begin
                cmd_o.finish = 1'b1;
              end else begin
                cmd_o.load = 1'b1;
                state_d    = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        busy       = 1'b1;
        cmd_o.step = 1'b1;
        if (stat_i.last_step) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `MOSA_ASSERT(a_walk_has_data, (state_q == ST_WALK) |-> (!stat_i.empty && !stat_i.dropped), "walk started without data")
  `MOSA_ASSERT(a_one_command, $onehot0({cmd_o.push_first, cmd_o.push_second, cmd_o.load, cmd_o.step}), "conflicting commands")
  `MOSA_ASSERT(a_finish_idles, cmd_o.finish |=> (state_q == ST_IDLE), "finish did not return to idle")

endmodule

// ===== rtl/core/mosa_dp.sv =====
// Datapath of the median unit: both element stores, counts, merge walk and result register.
// Depends on mosa_pkg and the shared assertion macros.
`include "median_of_two_sorted_arrays_unit_defines.svh"

module mosa_dp import mosa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output result_t result_o,
  output logic    result_valid_o
);

  logic [31:0] first_mem  [DEPTH];
  logic [31:0] second_mem [DEPTH];

  logic [CNT_W-1:0] first_count_q, second_count_q;
  logic             dropped_q;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, t_q;
  logic [31:0]      first_rd_q, second_rd_q;
  logic [31:0]      lo_val_q;
  result_t          result_q;
  logic             result_valid_q;

  logic [TOT_W-1:0] total;
  logic [CNT_W-1:0] lo_rank, hi_rank;
  logic             first_full, second_full;
  logic             first_avail, second_avail, take_first;
  logic [31:0]      cur, lo_sel;
  logic [32:0]      sum;

  assign total       = TOT_W'(first_count_q) + TOT_W'(second_count_q);
  assign lo_rank     = CNT_W'((total - TOT_W'(1)) >> 1);
  assign hi_rank     = CNT_W'(total >> 1);
  assign first_full  = (first_count_q == CNT_W'(DEPTH));
  assign second_full = (second_count_q == CNT_W'(DEPTH));

  // merge head choice, ties go to the first store
  assign first_avail  = (i_q < first_count_q);
  assign second_avail = (j_q < second_count_q);
  assign take_first   = first_avail &&
                        (!second_avail || ($signed(first_rd_q) <= $signed(second_rd_q)));
  assign cur          = take_first ? first_rd_q : (second_avail ? second_rd_q : '0);
  assign lo_sel       = (t_q == lo_rank) ? cur : lo_val_q;
  assign sum          = {lo_sel[31], lo_sel} + {cur[31], cur};

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.load) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.step) begin
      if (take_first) begin
        i_d = i_q + CNT_W'(1);
      end else if (second_avail) begin
        j_d = j_q + CNT_W'(1);
      end
    end
  end

  assign stat_o.dropped   = dropped_q;
  assign stat_o.empty     = (total == '0);
  assign stat_o.last_step = (t_q == hi_rank);

  // stores: write on push, read ahead at the next walk index
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_first && !first_full) begin
      first_mem[first_count_q[ADDR_W-1:0]] <= item_i.value;
    end
    first_rd_q <= first_mem[i_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_second && !second_full) begin
      second_mem[second_count_q[ADDR_W-1:0]] <= item_i.value;
    end
    second_rd_q <= second_mem[j_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      dropped_q      <= 1'b0;
      i_q            <= '0;
      j_q            <= '0;
      t_q            <= '0;
      result_valid_q <= 1'b0;
    end else begin
      i_q            <= i_d;
      j_q            <= j_d;
      result_valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        t_q <= '0;
      end else if (cmd_i.step) begin
        t_q <= t_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        first_count_q  <= '0;
        second_count_q <= '0;
        dropped_q      <= 1'b0;
      end else if (cmd_i.push_first) begin
        if (first_full) dropped_q <= 1'b1;
        else            first_count_q <= first_count_q + CNT_W'(1);
      end else if (cmd_i.push_second) begin
        if (second_full) dropped_q <= 1'b1;
        else             second_count_q <= second_count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && (t_q == lo_rank)) begin
      lo_val_q <= cur;
    end
    if (cmd_i.finish) begin
      priority if (dropped_q) begin
        result_q.status         <= STATUS_DROPPED;
        result_q.median_doubled <= '0;
      end else if (total == '0) begin
        result_q.status         <= STATUS_EMPTY;
        result_q.median_doubled <= '0;
      end else begin
        result_q.status         <= STATUS_OK;
        result_q.median_doubled <= $signed(sum);
      end
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  `MOSA_ASSERT(a_step_has_head, cmd_i.step |-> (first_avail || second_avail), "walk ran past both stores")
  `MOSA_ASSERT(a_counts_bounded, (first_count_q <= CNT_W'(DEPTH)) && (second_count_q <= CNT_W'(DEPTH)), "count beyond depth")
  `MOSA_ASSERT(a_bad_status_zero, (result_valid_q && (result_q.status != STATUS_OK)) |-> (result_q.median_doubled == '0), "non-zero median with bad status")
  `MOSA_ASSERT_ALWAYS(a_finish_clears, cmd_i.finish |=> ((first_count_q == '0) && (second_count_q == '0) && !dropped_q), "stores not cleared after result")

endmodule

// ===== rtl/core/median_of_two_sorted_arrays_unit.sv =====
// Top level of the median-of-two-sorted-arrays unit.
// Depends on mosa_pkg, mosa_ctrl and mosa_dp.
//
// Loads two nondecreasing arrays of signed 32-bit elements and reports twice the median of
// their union. A transaction is taken at a rising edge with start high and busy low. Kind
// push-first or push-second appends item_i.value to that array, with no result; a push to
// a full array (mosa_pkg::DEPTH entries) is dropped and remembered. Kind compute gives
// exactly one result, strobed by result_valid_o for one cycle, and clears both arrays and
// the drop flag. A compute after a drop reports STATUS_DROPPED, and with both arrays empty
// STATUS_EMPTY, each with a zero median, in the cycle after the transaction. Otherwise the
// unit walks the merge of both stores one element per cycle up to the upper middle rank
// (total being the number of stored elements): busy stays high during the walk and the
// result appears in the cycle that busy falls. The walk rate is set by the registered read
// port of each store, which delivers one new head per cycle. Pushes therefore run at one
// per cycle while busy is low. The median is doubled so that it is exact: for an odd total
// it is twice the middle element, for an even total the sum of the two middle elements
// (one fraction bit). Order is not checked; unsorted input gives the element of the
// required rank in a merge that takes the smaller head, the first array winning ties. The
// receiver cannot stall: capture the result in the cycle that result_valid_o is high.
// Kind 3 is ignored. No clearing pass follows reset; only entries below the counts are
// ever read.

module median_of_two_sorted_arrays_unit import mosa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    result_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequence transactions and the walk
  mosa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // hold the stores, advance the merge and register the result
  mosa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for median_of_two_sorted_arrays_unit.
// Depends on mosa_pkg and the unit's RTL; it predicts every result itself and
// checks each strobed result against the oldest prediction still waiting.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mosa_pkg::*;

  // Kind 3 has no meaning to the unit; it must be swallowed without a result.
  localparam logic [1:0] KIND_RESERVED  = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = DEPTH + 8;
  localparam int         RANDOM_ITEMS   = 450;
  localparam int         SHOWN_ERRORS   = 10;
  localparam int         INT_MAX        = 32'h7fff_ffff;
  localparam int         INT_MIN        = 32'h8000_0000;

  // One queued stimulus entry: a transaction preceded by an idle gap, or a
  // marker that holds the sender until every predicted result has arrived.
  typedef struct {
    item_t       item;
    int unsigned gap;
    bit          pause;
  } stim_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    result_valid_o;

  median_of_two_sorted_arrays_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  stim_t       stim_q[$];
  result_t     median_q[$];     // predicted results, oldest first
  int          first_vals[$];   // shadow of the first array
  int          second_vals[$];  // shadow of the second array
  bit          drop_seen;       // shadow of the overflow flag
  bit          taken = 1'b0;    // a transaction was accepted at the last rising edge
  int unsigned idle_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned random_items = 0;
  bit          steady;          // no idle gaps while set
  bit          overflow_done = 1'b0;  // the oversized set has been queued

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Walk the merge of both shadow arrays, smaller head first and the first
  // array winning ties, up to the upper middle rank. Sum the two middle
  // elements for an even total; for an odd total both ranks coincide.
  function automatic result_t merged_median();
    result_t     r;
    int unsigned total;
    int unsigned lo_rank;
    int unsigned hi_rank;
    int unsigned i;
    int unsigned j;
    longint      cur;
    longint      at_lo;
    longint      sum;
    bit          from_first;
    total   = first_vals.size() + second_vals.size();
    hi_rank = total / 2;
    lo_rank = (total % 2 == 1) ? hi_rank : hi_rank - 1;
    i       = 0;
    j       = 0;
    cur     = 0;
    at_lo   = 0;
    for (int unsigned t = 0; t <= hi_rank; t++) begin
      from_first = (i < first_vals.size()) &&
                   (j >= second_vals.size() || first_vals[i] <= second_vals[j]);
      if (from_first) begin
        cur = first_vals[i];
        i++;
      end else begin
        cur = second_vals[j];
        j++;
      end
      if (t == lo_rank) at_lo = cur;
    end
    sum              = at_lo + cur;
    r.median_doubled = sum[32:0];
    r.status         = STATUS_OK;
    return r;
  endfunction

  // Update the shadow state for one accepted transaction and queue the result
  // that a compute produces.
  task automatic apply_item(item_t it);
    result_t r;
    case (it.kind)
      KIND_PUSH_FIRST: begin
        if (first_vals.size() < DEPTH) first_vals.push_back(it.value);
        else drop_seen = 1'b1;
      end
      KIND_PUSH_SECOND: begin
        if (second_vals.size() < DEPTH) second_vals.push_back(it.value);
        else drop_seen = 1'b1;
      end
      KIND_COMPUTE: begin
        if (drop_seen) begin
          r.median_doubled = '0;
          r.status         = STATUS_DROPPED;
        end else if (first_vals.size() + second_vals.size() == 0) begin
          r.median_doubled = '0;
          r.status         = STATUS_EMPTY;
        end else begin
          r = merged_median();
        end
        median_q.push_back(r);
        first_vals.delete();
        second_vals.delete();
        drop_seen = 1'b0;
      end
      default: begin
        // reserved kind: no state change, no result
      end
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [32:0] want_v, logic [32:0] got_v);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic [1:0] kind, int value);
    stim_t s;
    s.item.kind  = kind;
    s.item.value = value;
    s.gap        = steady ? 0 : $urandom_range(0, 3);
    s.pause      = 1'b0;
    stim_q.push_back(s);
    if (kind != KIND_RESERVED) random_items++;
  endtask

  // Hold the sender until the unit has delivered everything outstanding.
  task automatic queue_pause();
    stim_t s;
    s.item  = '0;
    s.gap   = 0;
    s.pause = 1'b1;
    stim_q.push_back(s);
  endtask

  // Style 0 spans the full range, 1 a narrow band full of ties, 2 the extremes.
  function automatic int draw_value(int unsigned style);
    case (style)
      0: return $urandom;
      1: return int'($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 5))
          0: return INT_MIN;
          1: return INT_MIN + 1;
          2: return -1;
          3: return 0;
          4: return INT_MAX - 1;
          default: return INT_MAX;
        endcase
      end
    endcase
  endfunction

  // Load one data set into both arrays, interleaving the two streams at random
  // while keeping each in its own order, then ask for the median.
  task automatic queue_set(int unsigned n_first, int unsigned n_second, bit sorted,
                           int unsigned style);
    int          a[$];
    int          b[$];
    int unsigned i;
    int unsigned j;
    bit          pick_first;
    for (int unsigned k = 0; k < n_first; k++) a.push_back(draw_value(style));
    for (int unsigned k = 0; k < n_second; k++) b.push_back(draw_value(style));
    if (sorted) begin
      a.sort();
      b.sort();
    end
    i = 0;
    j = 0;
    while (i < n_first || j < n_second) begin
      pick_first = (j >= n_second) || (i < n_first && $urandom_range(0, 1) == 1);
      if (pick_first) begin
        queue_item(KIND_PUSH_FIRST, a[i]);
        i++;
      end else begin
        queue_item(KIND_PUSH_SECOND, b[j]);
        j++;
      end
      // sprinkle ignored transactions into the load stream
      if ($urandom_range(0, 19) == 0) queue_item(KIND_RESERVED, $urandom);
    end
    queue_item(KIND_COMPUTE, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only, one assignment per signal.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the transaction until the unit takes it
    end else if (stim_q.size() == 0) begin
      start <= 1'b0;
    end else if (stim_q[0].pause) begin
      start <= 1'b0;
      if (median_q.size() == 0) void'(stim_q.pop_front());
    end else if (idle_count < stim_q[0].gap) begin
      start      <= 1'b0;
      idle_count <= idle_count + 1;
    end else begin
      item_i     <= stim_q[0].item;
      start      <= 1'b1;
      idle_count <= 0;
      void'(stim_q.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check a strobed result before
  // predicting the transaction taken at the same edge, since a compute's
  // result never shows in the cycle it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (median_q.size() == 0) begin
          flag_mismatch("unexpected result", 'x, result_o.median_doubled);
        end else begin
          want = median_q.pop_front();
          if (result_o.status !== want.status)
            flag_mismatch("status", 33'(want.status), 33'(result_o.status));
          if (result_o.median_doubled !== want.median_doubled)
            flag_mismatch("median_doubled", want.median_doubled, result_o.median_doubled);
        end
      end else if (result_valid_o !== 1'b0) begin
        flag_mismatch("result_valid_o", 33'd0, 33'(result_valid_o));
      end
      if (start && busy === 1'b0) apply_item(item_i);
    end
    taken <= rst_ni && start && busy === 1'b0;
  end

  // Watchdog: give up after a long run of cycles with no transaction and no result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || result_valid_o === 1'b1) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the stimulus queue, release reset, drain, give the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed part: empty arrays, single elements at both extremes, an even
    // total spanning the range, ties, unsorted contents and an ignored kind.
    steady = 1'b0;
    queue_item(KIND_COMPUTE, INT_MAX);
    queue_pause();
    queue_item(KIND_PUSH_FIRST, INT_MAX);
    queue_item(KIND_COMPUTE, -1);
    queue_item(KIND_PUSH_SECOND, INT_MIN);
    queue_item(KIND_COMPUTE, 0);
    queue_item(KIND_PUSH_FIRST, INT_MIN);
    queue_item(KIND_PUSH_SECOND, INT_MAX);
    queue_item(KIND_COMPUTE, INT_MIN);
    queue_item(KIND_PUSH_FIRST, INT_MAX);
    queue_item(KIND_PUSH_SECOND, INT_MAX);
    queue_item(KIND_COMPUTE, 0);
    queue_item(KIND_PUSH_FIRST, 7);
    queue_item(KIND_PUSH_SECOND, 7);
    queue_item(KIND_COMPUTE, 0);
    queue_item(KIND_PUSH_FIRST, 9);
    queue_item(KIND_PUSH_FIRST, 1);
    queue_item(KIND_PUSH_SECOND, 5);
    queue_item(KIND_COMPUTE, 0);
    queue_item(KIND_RESERVED, -1);
    queue_item(KIND_COMPUTE, 0);
    queue_pause();

    // Random part: mostly small sorted sets with random content, some
    // unsorted ones, and one oversized set that overflows the first array.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) queue_pause();
      if (!overflow_done && random_items >= RANDOM_ITEMS / 4) begin
        overflow_done = 1'b1;
        queue_set(DEPTH + 1, 2, 1'b1, 0);
      end else if ($urandom_range(0, 9) == 0)
        queue_set($urandom_range(0, 20), $urandom_range(0, 20), 1'b1,
                  $urandom_range(0, 2));
      else
        queue_set($urandom_range(0, 6), $urandom_range(0, 6),
                  $urandom_range(0, 4) != 0, $urandom_range(0, 2));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || start) @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    // let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && median_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mosa_pkg.sv
rtl/core/mosa_ctrl.sv
rtl/core/mosa_dp.sv
rtl/core/median_of_two_sorted_arrays_unit.sv
dv/tb_top.sv
